[rtl/lss_pkg.sv]
package lss_pkg;

    // Field and datapath widths
    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 20;
    localparam int STEP_W   = 14;
    localparam int GAIN_W   = 10;
    localparam int TOTAL_W  = 40;
    localparam int SPEED_W  = 20;
    localparam int OFF_W    = 18;
    localparam int DVD_W    = 40;
    localparam int DVR_W    = 16;
    localparam int ITER_W   = 6;

    // Proximity score: 10 / meters in Q.8 is 2560000 / millimeters
    localparam int SCORE_NUM_W          = 22;
    localparam logic [SCORE_NUM_W-1:0] SCORE_NUM = SCORE_NUM_W'(2560000);
    localparam logic [TOTAL_W-1:0] ZERO_RANGE_SCORE = TOTAL_W'(2560);
    localparam logic [ITER_W-1:0] SCORE_ITERS = ITER_W'(SCORE_NUM_W);
    localparam logic [ITER_W-1:0] GAIN_ITERS  = ITER_W'(DVD_W);

    // Steering offset limits, Q.8
    localparam logic [OFF_W-1:0] OFFSET_MAX  = OFF_W'(1023 * 256);
    localparam logic [OFF_W-1:0] WALL_OFFSET = OFF_W'(80 * 256);

    // Sector bounds in millidegrees
    localparam int LEFT_LO  = -180000;
    localparam int LEFT_HI  = -120000;
    localparam int RIGHT_LO = 120000;
    localparam int RIGHT_HI = 180000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RANGE_LIMIT  = 3'd0,
        REG_SCORE_RANGE  = 3'd1,
        REG_FIRST_ANGLE  = 3'd2,
        REG_ANGLE_STEP   = 3'd3,
        REG_GAIN_DIVISOR = 3'd4,
        REG_WALL_SCORE   = 3'd5,
        REG_WALL_BALANCE = 3'd6,
        REG_BASE_SPEED   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [RANGE_W-1:0]        range_limit_mm;
        logic [RANGE_W-1:0]        score_range_mm;
        logic signed [ANGLE_W-1:0] first_angle_mdeg;
        logic [STEP_W-1:0]         angle_step_mdeg;
        logic [GAIN_W-1:0]         gain_divisor;
        logic [RANGE_W-1:0]        wall_score;
        logic [GAIN_W-1:0]         wall_balance;
        logic [GAIN_W-1:0]         base_speed;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SECTOR,
        ST_SCORE_DIV,
        ST_ACCUM,
        ST_DIFF,
        ST_GAIN_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic sector_eval;
        logic score_start;
        logic accum;
        logic diff_start;
        logic result_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic qualify;
        logic zero_range;
        logic last;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

[rtl/lss_div.sv]
module lss_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [lss_pkg::DVD_W-1:0]  dividend,
    input  logic [lss_pkg::DVR_W-1:0]  divisor,
    input  logic [lss_pkg::ITER_W-1:0] iters,
    output logic                      busy,
    output logic [lss_pkg::DVD_W-1:0]  quotient
);

    localparam logic [lss_pkg::ITER_W-1:0] ITER_ONE = lss_pkg::ITER_W'(1);

    logic [lss_pkg::DVR_W-1:0]  rem_reg, rem_next;
    logic [lss_pkg::DVD_W-1:0]  dq_reg, dq_next;
    logic [lss_pkg::DVR_W-1:0]  dvr_reg;
    logic [lss_pkg::ITER_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic [lss_pkg::DVR_W:0]    shifted;
    logic [lss_pkg::DVR_W+1:0]  trial;
    logic                       fits;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        shifted  = {rem_reg, dq_reg[lss_pkg::DVD_W-1]};
        trial    = {1'b0, shifted} - {2'b00, dvr_reg};
        fits     = !trial[lss_pkg::DVR_W+1];
        rem_next = fits ? trial[lss_pkg::DVR_W-1:0] : shifted[lss_pkg::DVR_W-1:0];
        dq_next  = {dq_reg[lss_pkg::DVD_W-2:0], fits};
    end

    // Control: count iterations down
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != ITER_ONE);
        end
    end

    // Payload: remainder and dividend/quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

[rtl/lss_datapath.sv]
module lss_datapath #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lss_pkg::cfg_t                cfg,
    input  lss_pkg::cmd_t                cmd,
    output lss_pkg::sts_t                sts,
    input  logic [lss_pkg::RANGE_W-1:0]  in_range_mm,
    input  logic                         in_range_valid,
    input  logic                         in_last,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [2*lss_pkg::SPEED_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser
);

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int PROD_W = lss_pkg::STEP_W + IDX_W;
    localparam int ANG_W  = PROD_W + 2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);
    localparam int SPD_X  = lss_pkg::OFF_W + 3;

    // Sample registers
    logic [lss_pkg::RANGE_W-1:0] mm_reg;
    logic                        valid_reg;
    logic                        last_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        side_right_reg;
    logic [lss_pkg::TOTAL_W-1:0] left_total_reg, left_total_next;
    logic [lss_pkg::TOTAL_W-1:0] right_total_reg, right_total_next;
    logic                        left_dom_reg;

    // Output register
    logic                          m_valid_reg;
    logic [2*lss_pkg::SPEED_W-1:0] m_data_reg;
    logic [1:0]                    m_user_reg;

    // Divider interface
    logic                         div_start;
    logic                         div_busy;
    logic [lss_pkg::DVD_W-1:0]    div_dividend;
    logic [lss_pkg::DVR_W-1:0]    div_divisor;
    logic [lss_pkg::ITER_W-1:0]   div_iters;
    logic [lss_pkg::DVD_W-1:0]    div_quotient;

    logic signed [ANG_W-1:0]     angle;
    logic                        in_left, in_right;
    logic [lss_pkg::TOTAL_W-1:0] score;
    logic [lss_pkg::TOTAL_W:0]   acc_sum;
    logic [lss_pkg::TOTAL_W-1:0] acc_base;
    logic [lss_pkg::TOTAL_W-1:0] acc_sat;
    logic                        left_gt;
    logic [lss_pkg::TOTAL_W-1:0] abs_diff;
    logic [lss_pkg::GAIN_W-1:0]  gain_eff;
    logic [lss_pkg::OFF_W-1:0]   off_mag, off_final;
    logic                        wall;
    logic signed [SPD_X-1:0]     off_s, base_s, left_sp, right_sp;

    // Sector test on the registered product
    always_comb begin
        angle    = ANG_W'(cfg.first_angle_mdeg) + $signed({2'b00, prod_reg});
        in_left  = (angle >= ANG_W'(lss_pkg::LEFT_LO)) && (angle < ANG_W'(lss_pkg::LEFT_HI));
        in_right = (angle >= ANG_W'(lss_pkg::RIGHT_LO)) && (angle < ANG_W'(lss_pkg::RIGHT_HI));
    end

    assign sts.qualify    = valid_reg && (mm_reg < cfg.range_limit_mm)
                            && (mm_reg < cfg.score_range_mm) && (in_left || in_right);
    assign sts.zero_range = (mm_reg == '0);
    assign sts.last       = last_reg;
    assign sts.div_busy   = div_busy;
    assign sts.out_free   = !m_valid_reg || m_tready;

    // Divider operand select: proximity score or gain division
    always_comb begin
        gain_eff  = (cfg.gain_divisor == '0) ? lss_pkg::GAIN_W'(1) : cfg.gain_divisor;
        left_gt   = left_total_reg > right_total_reg;
        abs_diff  = left_gt ? left_total_reg - right_total_reg
                            : right_total_reg - left_total_reg;
        div_start = cmd.score_start || cmd.diff_start;
        if (cmd.score_start) begin
            div_dividend = {lss_pkg::SCORE_NUM, (lss_pkg::DVD_W - lss_pkg::SCORE_NUM_W)'(0)};
            div_divisor  = mm_reg;
            div_iters    = lss_pkg::SCORE_ITERS;
        end else begin
            div_dividend = abs_diff;
            div_divisor  = lss_pkg::DVR_W'(gain_eff);
            div_iters    = lss_pkg::GAIN_ITERS;
        end
    end

    lss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Saturating accumulate into the chosen side
    always_comb begin
        score    = sts.zero_range ? lss_pkg::ZERO_RANGE_SCORE : div_quotient;
        acc_base = side_right_reg ? right_total_reg : left_total_reg;
        acc_sum  = {1'b0, acc_base} + {1'b0, score};
        acc_sat  = acc_sum[lss_pkg::TOTAL_W] ? '1 : acc_sum[lss_pkg::TOTAL_W-1:0];
        left_total_next  = left_total_reg;
        right_total_next = right_total_reg;
        if (cmd.result_load) begin
            left_total_next  = '0;
            right_total_next = '0;
        end else if (cmd.accum) begin
            if (side_right_reg) begin
                right_total_next = acc_sat;
            end else begin
                left_total_next = acc_sat;
            end
        end
    end

    // Offset, wall rule and wheel speeds
    always_comb begin
        off_mag = (div_quotient > lss_pkg::DVD_W'(lss_pkg::OFFSET_MAX))
                  ? lss_pkg::OFFSET_MAX : div_quotient[lss_pkg::OFF_W-1:0];
        wall = (off_mag < {cfg.wall_balance, 8'h00})
               && (left_total_reg >= lss_pkg::TOTAL_W'({cfg.wall_score, 8'h00}))
               && (right_total_reg >= lss_pkg::TOTAL_W'({cfg.wall_score, 8'h00}));
        off_final = wall ? lss_pkg::WALL_OFFSET : off_mag;
        off_s     = left_dom_reg ? $signed(SPD_X'(off_final)) : -$signed(SPD_X'(off_final));
        base_s    = $signed(SPD_X'({cfg.base_speed, 8'h00}));
        left_sp   = base_s + off_s;
        right_sp  = off_s - base_s;
    end

    // Control registers: index, totals, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            left_total_reg  <= left_total_next;
            right_total_reg <= right_total_next;
            if (cmd.result_load) begin
                idx_reg <= '0;
            end else if (cmd.load_in) begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mm_reg    <= in_range_mm;
            valid_reg <= in_range_valid;
            last_reg  <= in_last;
            prod_reg  <= PROD_W'(cfg.angle_step_mdeg * idx_reg);
        end
        if (cmd.sector_eval) begin
            side_right_reg <= !in_left;
        end
        if (cmd.diff_start) begin
            left_dom_reg <= left_gt;
        end
        if (cmd.result_load) begin
            m_data_reg <= {right_sp[lss_pkg::SPEED_W-1:0], left_sp[lss_pkg::SPEED_W-1:0]};
            m_user_reg <= {left_dom_reg, wall};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> (!m_valid_reg || m_tready))
        else $error("result overwrites a word not yet taken");

    a_scan_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |=> (left_total_reg == '0) && (right_total_reg == '0)
                            && (idx_reg == '0))
        else $error("scan state not cleared after result");

    a_accum_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accum |-> !div_busy)
        else $error("score added while division in progress");

endmodule

[rtl/lss_ctrl.sv]
module lss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lss_pkg::sts_t sts,
    output lss_pkg::cmd_t cmd
);

    lss_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            lss_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = lss_pkg::ST_SECTOR;
                end
            end
            lss_pkg::ST_SECTOR: begin
                cmd.sector_eval = 1'b1;
                priority if (sts.qualify && sts.zero_range) begin
                    state_next = lss_pkg::ST_ACCUM;
                end else if (sts.qualify) begin
                    cmd.score_start = 1'b1;
                    state_next      = lss_pkg::ST_SCORE_DIV;
                end else if (sts.last) begin
                    state_next = lss_pkg::ST_DIFF;
                end else begin
                    state_next = lss_pkg::ST_IDLE;
                end
            end
            lss_pkg::ST_SCORE_DIV: begin
                if (!sts.div_busy) begin
                    state_next = lss_pkg::ST_ACCUM;
                end
            end
            lss_pkg::ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = sts.last ? lss_pkg::ST_DIFF : lss_pkg::ST_IDLE;
            end
            lss_pkg::ST_DIFF: begin
                cmd.diff_start = 1'b1;
                state_next     = lss_pkg::ST_GAIN_DIV;
            end
            lss_pkg::ST_GAIN_DIV: begin
                if (!sts.div_busy) begin
                    state_next = lss_pkg::ST_EMIT;
                end
            end
            lss_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = lss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lidar_sector_steering.sv]
// Channel   Dir  Word / fields
// s_        in   tdata[15:0] range_mm, tuser[0] range_valid, tlast last_sample
// m_        out  tdata[19:0] left_speed, tdata[39:20] right_speed,
//                tuser[0] wall_seen, tuser[1] left_dominant
// APB       in   8 registers at byte address 4*i, 32-bit data
//
// A sample that adds no score stops at the sector check; one at zero range
// adds an accumulate step, and any other waits on the 22-step shared
// restoring divider. A scan's last sample adds the 40-step gain division.
// Reset is synchronous, active low; no clearing pass is needed.
// A waiting result stalls only the final step of the next scan.
module lidar_sector_steering #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] range_mm
    input  logic [0:0]  s_tuser,   // [0] range_valid
    input  logic        s_tlast,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [19:0] left_speed, [39:20] right_speed
    output logic [1:0]  m_tuser,   // [0] wall_seen, [1] left_dominant
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lss_pkg::cfg_t    cfg_reg;
    lss_pkg::cmd_t    cmd;
    lss_pkg::sts_t    sts;
    lss_pkg::reg_idx_t reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = lss_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_limit_mm   <= 16'd3000;
            cfg_reg.score_range_mm   <= 16'd1500;
            cfg_reg.first_angle_mdeg <= 20'(-180000);
            cfg_reg.angle_step_mdeg  <= 14'd500;
            cfg_reg.gain_divisor     <= 10'd70;
            cfg_reg.wall_score       <= 16'd750;
            cfg_reg.wall_balance     <= 10'd7;
            cfg_reg.base_speed       <= 10'd100;
        end else if (wr_en) begin
            unique case (reg_idx)
                lss_pkg::REG_RANGE_LIMIT:  cfg_reg.range_limit_mm   <= pwdata[15:0];
                lss_pkg::REG_SCORE_RANGE:  cfg_reg.score_range_mm   <= pwdata[15:0];
                lss_pkg::REG_FIRST_ANGLE:  cfg_reg.first_angle_mdeg <= pwdata[19:0];
                lss_pkg::REG_ANGLE_STEP:   cfg_reg.angle_step_mdeg  <= pwdata[13:0];
                lss_pkg::REG_GAIN_DIVISOR: cfg_reg.gain_divisor     <= pwdata[9:0];
                lss_pkg::REG_WALL_SCORE:   cfg_reg.wall_score       <= pwdata[15:0];
                lss_pkg::REG_WALL_BALANCE: cfg_reg.wall_balance     <= pwdata[9:0];
                lss_pkg::REG_BASE_SPEED:   cfg_reg.base_speed       <= pwdata[9:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            lss_pkg::REG_RANGE_LIMIT:  prdata = 32'(cfg_reg.range_limit_mm);
            lss_pkg::REG_SCORE_RANGE:  prdata = 32'(cfg_reg.score_range_mm);
            lss_pkg::REG_FIRST_ANGLE:  prdata = 32'(cfg_reg.first_angle_mdeg);
            lss_pkg::REG_ANGLE_STEP:   prdata = 32'(cfg_reg.angle_step_mdeg);
            lss_pkg::REG_GAIN_DIVISOR: prdata = 32'(cfg_reg.gain_divisor);
            lss_pkg::REG_WALL_SCORE:   prdata = 32'(cfg_reg.wall_score);
            lss_pkg::REG_WALL_BALANCE: prdata = 32'(cfg_reg.wall_balance);
            lss_pkg::REG_BASE_SPEED:   prdata = 32'(cfg_reg.base_speed);
        endcase
    end

    lss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lss_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .in_range_mm    (s_tdata),
        .in_range_valid (s_tuser[0]),
        .in_last        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int SAMPLE_WRAP   = 4096;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_WORDS  = 960;

    // One pair of wheel speeds as the block emits it
    typedef struct packed {
        logic signed [lss_pkg::SPEED_W-1:0] left_speed;
        logic signed [lss_pkg::SPEED_W-1:0] right_speed;
        logic                               wall_seen;
        logic                               left_dominant;
    } steer_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    typedef enum logic [2:0] {
        GEO_BOTH, GEO_LEFT, GEO_RIGHT, GEO_ANY, GEO_FAR_LOW, GEO_FAR_HIGH
    } geo_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] range_mm
    logic [0:0]  s_tuser  = '0;    // [0] range_valid
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [19:0] left_speed, [39:20] right_speed
    logic [1:0]  m_tuser;          // [0] wall_seen, [1] left_dominant
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Scan state and register copy of the predictor
    lss_pkg::cfg_t cfg;
    int          scan_index;
    logic [39:0] left_sum;
    logic [39:0] right_sum;
    steer_t      expected_speeds[$];

    int          mismatch_count = 0;
    int          burst_left     = 0;
    int          hold_req       = 0;
    int          hold_left      = 0;
    int          seg_left       = 0;
    rx_mode_t    rx_mode        = RX_OPEN;
    int          quiet_cycles   = 0;

    lidar_sector_steering #(.MAX_SAMPLES(SAMPLE_WRAP)) DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic lss_pkg::cfg_t make_cfg(int lim, int near, int first, int step,
                                               int gain, int wscore, int wbal, int base);
        lss_pkg::cfg_t c;
        c.range_limit_mm   = lim[15:0];
        c.score_range_mm   = near[15:0];
        c.first_angle_mdeg = first[19:0];
        c.angle_step_mdeg  = step[13:0];
        c.gain_divisor     = gain[9:0];
        c.wall_score       = wscore[15:0];
        c.wall_balance     = wbal[9:0];
        c.base_speed       = base[9:0];
        return c;
    endfunction

    // Accumulate one sample; on the last one form the expected speed pair
    function automatic void steer_on_sample(logic [15:0] mm, logic ok, logic is_last);
        longint      ang;
        logic [39:0] score;
        logic [40:0] sum;
        logic [39:0] diff;
        logic [39:0] quot;
        longint      off;
        longint      base;
        logic        lead;
        logic        wall;
        steer_t      pair;
        if (ok && mm < cfg.range_limit_mm && mm < cfg.score_range_mm) begin
            ang = longint'($signed(cfg.first_angle_mdeg))
                + longint'(cfg.angle_step_mdeg) * longint'(scan_index);
            score = (mm == 16'd0) ? 40'd2560 : 40'(2560000 / int'(mm));
            if (ang >= lss_pkg::LEFT_LO && ang < lss_pkg::LEFT_HI) begin
                sum = {1'b0, left_sum} + {1'b0, score};
                left_sum = sum[40] ? '1 : sum[39:0];
            end else if (ang >= lss_pkg::RIGHT_LO && ang < lss_pkg::RIGHT_HI) begin
                sum = {1'b0, right_sum} + {1'b0, score};
                right_sum = sum[40] ? '1 : sum[39:0];
            end
        end
        scan_index = (scan_index + 1) % SAMPLE_WRAP;
        if (!is_last)
            return;

        lead = left_sum > right_sum;
        diff = lead ? left_sum - right_sum : right_sum - left_sum;
        quot = diff / ((cfg.gain_divisor == '0) ? 40'd1 : 40'(cfg.gain_divisor));
        off  = (quot > 40'(lss_pkg::OFFSET_MAX)) ? longint'(lss_pkg::OFFSET_MAX)
                                                 : longint'(quot);
        wall = off < longint'(cfg.wall_balance) * 256
            && left_sum >= (40'(cfg.wall_score) << 8)
            && right_sum >= (40'(cfg.wall_score) << 8);
        if (wall)
            off = longint'(lss_pkg::WALL_OFFSET);
        if (!lead)
            off = -off;
        base = longint'(cfg.base_speed) * 256;
        pair.left_speed    = lss_pkg::SPEED_W'(base + off);
        pair.right_speed   = lss_pkg::SPEED_W'(off - base);
        pair.wall_seen     = wall;
        pair.left_dominant = lead;
        expected_speeds.push_back(pair);

        scan_index = 0;
        left_sum   = '0;
        right_sum  = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR %0t: %s", $realtime, msg);
    endtask

    // Write one register: setup cycle, then access cycle
    task automatic write_reg(input lss_pkg::reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            lss_pkg::REG_RANGE_LIMIT:  cfg.range_limit_mm   = value[15:0];
            lss_pkg::REG_SCORE_RANGE:  cfg.score_range_mm   = value[15:0];
            lss_pkg::REG_FIRST_ANGLE:  cfg.first_angle_mdeg = value[19:0];
            lss_pkg::REG_ANGLE_STEP:   cfg.angle_step_mdeg  = value[13:0];
            lss_pkg::REG_GAIN_DIVISOR: cfg.gain_divisor     = value[9:0];
            lss_pkg::REG_WALL_SCORE:   cfg.wall_score       = value[15:0];
            lss_pkg::REG_WALL_BALANCE: cfg.wall_balance     = value[9:0];
            default:                   cfg.base_speed       = value[9:0];
        endcase
    endtask

    task automatic apply_config(input lss_pkg::cfg_t c);
        write_reg(lss_pkg::REG_RANGE_LIMIT,  int'(c.range_limit_mm));
        write_reg(lss_pkg::REG_SCORE_RANGE,  int'(c.score_range_mm));
        write_reg(lss_pkg::REG_FIRST_ANGLE,  int'($signed(c.first_angle_mdeg)));
        write_reg(lss_pkg::REG_ANGLE_STEP,   int'(c.angle_step_mdeg));
        write_reg(lss_pkg::REG_GAIN_DIVISOR, int'(c.gain_divisor));
        write_reg(lss_pkg::REG_WALL_SCORE,   int'(c.wall_score));
        write_reg(lss_pkg::REG_WALL_BALANCE, int'(c.wall_balance));
        write_reg(lss_pkg::REG_BASE_SPEED,   int'(c.base_speed));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one word; bursts of random length, most of them after an idle gap
    task automatic send_sample(input logic [15:0] mm, input logic ok, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= mm;
        s_tuser  <= ok;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        steer_on_sample(mm, ok, is_last);
    endtask

    function automatic logic [15:0] pick_range_mm();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1, 2:    return 16'($urandom_range(1, 255));
            3, 4, 5: return 16'($urandom_range(256, 2999));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_value(int lo, int hi, int usual);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            2, 3, 4: return usual;
            default: return int'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic send_scan(input int len);
        int n;
        for (n = 0; n < len; n++)
            send_sample(pick_range_mm(), $urandom_range(0, 7) != 0, n == len - 1);
    endtask

    // Stop offering, then let every pending result drain and the block settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_speeds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Reset registers: left score, near, invalid, at-limit and far samples
    task automatic test_basic_scan();
        send_sample(16'd0,     1'b1, 1'b0);
        send_sample(16'd1499,  1'b1, 1'b0);
        send_sample(16'd1500,  1'b1, 1'b0);
        send_sample(16'd100,   1'b0, 1'b0);
        send_sample(16'd3000,  1'b1, 1'b0);
        send_sample(16'hFFFF,  1'b1, 1'b1);
        wait_for_results();
    endtask

    // Huge right score with unit gain clips the offset
    task automatic test_offset_saturation();
        apply_config(make_cfg(65535, 65535, lss_pkg::RIGHT_LO, 0, 1, 65535, 1023, 1023));
        send_sample(16'd1,     1'b1, 1'b0);
        send_sample(16'd65534, 1'b1, 1'b0);
        send_sample(16'hFFFF,  1'b1, 1'b1);
        wait_for_results();
    endtask

    task automatic test_zero_divisor();
        apply_config(make_cfg(65535, 65535, lss_pkg::LEFT_LO, 10000, 0, 0, 0, 0));
        send_sample(16'd20,    1'b1, 1'b0);
        send_sample(16'd40000, 1'b1, 1'b1);
        wait_for_results();
    endtask

    // Angles just outside both sectors; empty totals with and without a wall
    task automatic test_out_of_sector();
        apply_config(make_cfg(3000, 1500, lss_pkg::LEFT_HI, 0, 70, 0, 1023, 1023));
        send_sample(16'd0, 1'b1, 1'b1);
        wait_for_results();
        apply_config(make_cfg(3000, 1500, lss_pkg::RIGHT_HI, 10000, 70, 0, 0, 1023));
        send_sample(16'd0, 1'b1, 1'b0);
        send_sample(16'd0, 1'b1, 1'b1);
        wait_for_results();
    endtask

    // Hold the result side while short scans keep coming
    task automatic test_backpressure();
        apply_config(make_cfg(3000, 1500, lss_pkg::LEFT_LO, 0, 70, 750, 7, 100));
        hold_req = HOLD_CYCLES;
        repeat (6) send_scan(1);
        wait_for_results();
    endtask

    // Phases of random registers and scan geometry, a few scans each
    task automatic test_random_scans();
        int   words;
        int   len;
        int   len_lo;
        int   len_hi;
        int   first;
        int   step;
        geo_t geo;
        words = 0;
        while (words < RANDOM_WORDS) begin
            geo = geo_t'($urandom_range(0, 5));
            case (geo)
                GEO_BOTH: begin
                    first = lss_pkg::LEFT_LO;  step = 10000; len_lo = 31; len_hi = 40;
                end
                GEO_LEFT: begin
                    first = lss_pkg::LEFT_LO;  step = 0;     len_lo = 1;  len_hi = 8;
                end
                GEO_RIGHT: begin
                    first = lss_pkg::RIGHT_LO; step = 0;     len_lo = 1;  len_hi = 8;
                end
                GEO_FAR_LOW: begin
                    first = -360000;  step = 10000; len_lo = 50; len_hi = 56;
                end
                GEO_FAR_HIGH: begin
                    first = 360000;   step = $urandom_range(0, 10000);
                    len_lo = 1;       len_hi = 10;
                end
                default: begin
                    first = int'($urandom_range(0, 720000)) - 360000;
                    step  = $urandom_range(0, 10000);
                    len_lo = 1;       len_hi = 40;
                end
            endcase
            apply_config(make_cfg(pick_value(0, 65535, 3000), pick_value(0, 65535, 1500),
                                  first, step, pick_value(0, 1023, 70),
                                  pick_value(0, 65535, 10), pick_value(0, 1023, 300),
                                  pick_value(0, 1023, 100)));
            repeat ($urandom_range(2, 6)) begin
                len = $urandom_range(len_lo, len_hi);
                send_scan(len);
                words += len;
            end
            wait_for_results();
        end
    endtask

    // Result side: stall pattern in segments, long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (seg_left == 0) begin
            seg_left = $urandom_range(32, 256);
            rx_mode  = rx_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= $urandom_range(0, 1) != 0;
                RX_SPARSE: m_tready <= $urandom_range(0, 7) == 0;
                default:   m_tready <= $urandom_range(0, 3) != 0;
            endcase
        end
    end

    // Compare each result word with the oldest expected pair
    always @(posedge aclk) begin
        steer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_speeds.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                          m_tdata, m_tuser));
            end else begin
                want = expected_speeds.pop_front();
                if (m_tdata[19:0] !== want.left_speed)
                    report_mismatch($sformatf("left_speed got %0d expected %0d",
                                              $signed(m_tdata[19:0]), want.left_speed));
                if (m_tdata[39:20] !== want.right_speed)
                    report_mismatch($sformatf("right_speed got %0d expected %0d",
                                              $signed(m_tdata[39:20]), want.right_speed));
                if (m_tuser[0] !== want.wall_seen)
                    report_mismatch($sformatf("wall_seen got %b expected %b",
                                              m_tuser[0], want.wall_seen));
                if (m_tuser[1] !== want.left_dominant)
                    report_mismatch($sformatf("left_dominant got %b expected %b",
                                              m_tuser[1], want.left_dominant));
            end
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("ERROR %0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        cfg        = make_cfg(3000, 1500, -180000, 500, 70, 750, 7, 100);
        scan_index = 0;
        left_sum   = '0;
        right_sum  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_scan();
        test_offset_saturation();
        test_zero_divisor();
        test_out_of_sector();
        test_backpressure();
        test_random_scans();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/lss_pkg.sv
rtl/lss_div.sv
rtl/lss_datapath.sv
rtl/lss_ctrl.sv
rtl/lidar_sector_steering.sv
test/tb.sv
